/* hdl/snhr_pkg.sv */
// Package: shared beat types and protocol codes for the static NAT header rewrite block.
package snhr_pkg;

    localparam logic       KIND_ENTRY  = 1'b0;
    localparam logic       KIND_HEADER = 1'b1;
    localparam logic       DIR_FWD     = 1'b0;
    localparam logic       DIR_REV     = 1'b1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [15:0] CK_ONES    = 16'hffff;

    typedef struct packed {
        logic        kind;
        logic        direction;
        logic [3:0]  entry_index;
        logic [31:0] entry_inside_start;
        logic [31:0] entry_outside_start;
        logic [31:0] entry_span;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] header_checksum;
        logic [7:0]  protocol_number;
        logic [15:0] transport_checksum;
    } cmd_t;

    typedef struct packed {
        logic        translated;
        logic [31:0] out_source_address;
        logic [31:0] out_destination_address;
        logic [15:0] out_header_checksum;
        logic [15:0] out_transport_checksum;
    } result_t;

    // beat handed from cell to cell
    typedef struct packed {
        logic        valid;
        cmd_t        cmd;
        logic        hit;
        logic [31:0] new_addr;
    } beat_t;

endpackage

/* hdl/static_nat_header_rewrite_top.sv */
// Top level: static NAT header rewrite, a chain of table cells followed by the checksum stage.
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+--------------------------------------
//  command   | start, busy, cmd        | beat taken when start && !busy
//  result    | result_valid, result    | one-cycle strobe, no back-pressure
//  config    | cfg_we, cfg_wdata       | active_pairs written when cfg_we
//
// A beat enters the cell chain in every cycle that start is high; busy is always low.
// A header beat yields its result once it has passed the register in each table cell
// and then the two checksum stages. Entry writes give no result.
// Entry writes travel the same chain, so they take effect in order with headers.
// Reset clears the pipeline valids and active_pairs; table contents are not cleared.
module static_nat_header_rewrite_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  snhr_pkg::cmd_t     cmd,
    output logic               result_valid,
    output snhr_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata
);
    import snhr_pkg::*;

    logic [4:0] active_reg;
    beat_t      chain [TABLE_DEPTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid    = start && !busy;
        chain[0].cmd      = cmd;
        chain[0].hit      = 1'b0;
        chain[0].new_addr = 32'd0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        snhr_cell #(
            .IDX(i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .active_pairs (active_reg),
            .beat_in      (chain[i]),
            .beat_out     (chain[i+1])
        );
    end

    snhr_csum u_csum (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_in      (chain[TABLE_DEPTH]),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hdl/snhr_cell.sv */
// Chain cell: holds one table entry, captures entry writes and matches passing headers.
module snhr_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     active_pairs,
    input  snhr_pkg::beat_t beat_in,
    output snhr_pkg::beat_t beat_out
);
    import snhr_pkg::*;

    localparam logic [7:0] IDX_SEL = IDX[7:0];
    localparam logic [8:0] IDX_ACT = IDX[8:0];

    logic [31:0] in_start_reg;
    logic [31:0] out_start_reg;
    logic [32:0] in_end_reg;
    logic [32:0] out_end_reg;
    logic [31:0] fwd_diff_reg;
    logic [31:0] rev_diff_reg;

    logic        valid_reg;
    beat_t       beat_reg;
    beat_t       beat_next;

    logic        wr_sel;
    logic        active;
    logic [31:0] addr;
    logic [31:0] start_sel;
    logic [32:0] end_sel;
    logic [31:0] diff_sel;
    logic        in_range;

    assign wr_sel = beat_in.valid && (beat_in.cmd.kind == KIND_ENTRY)
                    && ({4'b0, beat_in.cmd.entry_index} == IDX_SEL);
    assign active = {4'b0, active_pairs} > IDX_ACT;

    always_comb
    begin
        if (beat_in.cmd.direction == DIR_REV)
        begin
            addr      = beat_in.cmd.destination_address;
            start_sel = out_start_reg;
            end_sel   = out_end_reg;
            diff_sel  = rev_diff_reg;
        end
        else
        begin
            addr      = beat_in.cmd.source_address;
            start_sel = in_start_reg;
            end_sel   = in_end_reg;
            diff_sel  = fwd_diff_reg;
        end
        in_range = (addr >= start_sel) && ({1'b0, addr} < end_sel);

        beat_next = beat_in;
        if (beat_in.cmd.kind == KIND_HEADER && !beat_in.hit && active && in_range)
        begin
            beat_next.hit      = 1'b1;
            beat_next.new_addr = addr + diff_sel;
        end
    end

    // ends and offsets precomputed at write time
    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            in_start_reg  <= beat_in.cmd.entry_inside_start;
            out_start_reg <= beat_in.cmd.entry_outside_start;
            in_end_reg    <= {1'b0, beat_in.cmd.entry_inside_start}
                             + {1'b0, beat_in.cmd.entry_span};
            out_end_reg   <= {1'b0, beat_in.cmd.entry_outside_start}
                             + {1'b0, beat_in.cmd.entry_span};
            fwd_diff_reg  <= beat_in.cmd.entry_outside_start - beat_in.cmd.entry_inside_start;
            rev_diff_reg  <= beat_in.cmd.entry_inside_start - beat_in.cmd.entry_outside_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_comb
    begin
        beat_out       = beat_reg;
        beat_out.valid = valid_reg;
    end

endmodule

/* hdl/snhr_csum.sv */
// Checksum stage: RFC 1624 incremental patch of IP and L4 checksums, two registers deep.
module snhr_csum (
    input  logic                clk,
    input  logic                rst_n,
    input  snhr_pkg::beat_t     beat_in,
    output logic                result_valid,
    output snhr_pkg::result_t   result
);
    import snhr_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    beat_t       s1_beat_reg;
    logic [18:0] s1_hsum_reg;
    logic [18:0] s1_tsum_reg;
    logic [18:0] hsum_next;
    logic [18:0] tsum_next;

    logic        s2_valid_reg;
    result_t     s2_res_reg;
    result_t     s2_res_next;

    logic [31:0] old_addr;
    logic [18:0] delta;
    logic [15:0] h_patch;
    logic [15:0] t_patch;
    logic        tcp;
    logic        udp_on;

    function automatic logic [15:0] fold_inv(input logic [18:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
        return ~s2[15:0];
    endfunction

    assign s1_valid_next = beat_in.valid && (beat_in.cmd.kind == KIND_HEADER);

    always_comb
    begin
        old_addr = (beat_in.cmd.direction == DIR_REV) ? beat_in.cmd.destination_address
                                                      : beat_in.cmd.source_address;
        delta    = {3'b0, ~old_addr[31:16]} + {3'b0, ~old_addr[15:0]}
                   + {3'b0, beat_in.new_addr[31:16]} + {3'b0, beat_in.new_addr[15:0]};
        hsum_next = delta + {3'b0, ~beat_in.cmd.header_checksum};
        tsum_next = delta + {3'b0, ~beat_in.cmd.transport_checksum};
    end

    always_ff @(posedge clk)
    begin
        s1_beat_reg <= beat_in;
        s1_hsum_reg <= hsum_next;
        s1_tsum_reg <= tsum_next;
        s2_res_reg  <= s2_res_next;
    end

    always_comb
    begin
        h_patch = fold_inv(s1_hsum_reg);
        t_patch = fold_inv(s1_tsum_reg);
        tcp     = s1_beat_reg.cmd.protocol_number == PROTO_TCP;
        udp_on  = (s1_beat_reg.cmd.protocol_number == PROTO_UDP)
                  && (s1_beat_reg.cmd.transport_checksum != 16'h0000);

        s2_res_next.translated              = s1_beat_reg.hit;
        s2_res_next.out_source_address      = s1_beat_reg.cmd.source_address;
        s2_res_next.out_destination_address = s1_beat_reg.cmd.destination_address;
        s2_res_next.out_header_checksum     = s1_beat_reg.cmd.header_checksum;
        s2_res_next.out_transport_checksum  = s1_beat_reg.cmd.transport_checksum;
        if (s1_beat_reg.hit)
        begin
            if (s1_beat_reg.cmd.direction == DIR_REV)
            begin
                s2_res_next.out_destination_address = s1_beat_reg.new_addr;
            end
            else
            begin
                s2_res_next.out_source_address = s1_beat_reg.new_addr;
            end
            s2_res_next.out_header_checksum = h_patch;
            if (tcp)
            begin
                s2_res_next.out_transport_checksum = t_patch;
            end
            else if (udp_on)
            begin
                s2_res_next.out_transport_checksum = (t_patch == 16'h0000) ? CK_ONES : t_patch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign result_valid = s2_valid_reg;
    assign result       = s2_res_reg;

endmodule

/* hdl/snhr_check.sv */
// Port checker for the static NAT header rewrite top level, with its bind.
module snhr_check #(
    parameter int TABLE_DEPTH = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input snhr_pkg::cmd_t     cmd,
    input logic               result_valid,
    input snhr_pkg::result_t  result
);
    import snhr_pkg::*;

    localparam int LAT = TABLE_DEPTH + 2;

    a_hdr_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == KIND_HEADER) |-> ##LAT result_valid)
        else $error("header beat without result");

    a_result_from_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && cmd.kind == KIND_HEADER, LAT))
        else $error("result without header beat");

    a_miss_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.translated) |->
            (result.out_source_address == $past(cmd.source_address, LAT)
             && result.out_destination_address == $past(cmd.destination_address, LAT)
             && result.out_header_checksum == $past(cmd.header_checksum, LAT)))
        else $error("unmatched header altered");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(cmd.direction, LAT) == DIR_FWD) |->
            (result.out_destination_address == $past(cmd.destination_address, LAT)))
        else $error("forward beat changed destination");

endmodule

bind static_nat_header_rewrite_top snhr_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_snhr_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);

/* sim/static_nat_header_rewrite_top_tb.sv */
// Testbench for the static NAT header rewrite block: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module static_nat_header_rewrite_top_tb;

    import snhr_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int LATENCY        = TABLE_DEPTH + 2;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEMS_PER_SET  = 185;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        result_valid;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    // predictor state
    logic [31:0] nat_inside [TABLE_DEPTH];
    logic [31:0] nat_outside [TABLE_DEPTH];
    logic [31:0] nat_span [TABLE_DEPTH];
    logic [4:0]  nat_active = '0;
    result_t     pending_rewrites [$];

    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          idling_on = 1'b1;

    static_nat_header_rewrite_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // RFC 1624 incremental update for a 32-bit field change
    function automatic logic [15:0] ones_patch(input logic [15:0] ck, input logic [31:0] was,
                                               input logic [31:0] now);
        logic [31:0] s;
        s = {16'h0, ~ck} + {16'h0, ~was[31:16]} + {16'h0, ~was[15:0]}
            + {16'h0, now[31:16]} + {16'h0, now[15:0]};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic result_t rewrite_header(input cmd_t c);
        result_t     r;
        logic [31:0] addr;
        logic [31:0] base;
        logic [31:0] moved;
        logic [32:0] top;
        int unsigned n;
        r.translated              = 1'b0;
        r.out_source_address      = c.source_address;
        r.out_destination_address = c.destination_address;
        r.out_header_checksum     = c.header_checksum;
        r.out_transport_checksum  = c.transport_checksum;
        n = (nat_active > TABLE_DEPTH) ? TABLE_DEPTH : nat_active;
        addr = (c.direction == DIR_REV) ? c.destination_address : c.source_address;
        for (int i = 0; i < n; i++)
        begin
            if (!r.translated)
            begin
                base = (c.direction == DIR_REV) ? nat_outside[i] : nat_inside[i];
                top  = {1'b0, base} + {1'b0, nat_span[i]};
                if (addr >= base && {1'b0, addr} < top)
                begin
                    moved = (c.direction == DIR_REV) ? addr + (nat_inside[i] - nat_outside[i])
                                                     : addr + (nat_outside[i] - nat_inside[i]);
                    r.translated = 1'b1;
                    r.out_header_checksum = ones_patch(c.header_checksum, addr, moved);
                    if (c.protocol_number == PROTO_TCP)
                    begin
                        r.out_transport_checksum = ones_patch(c.transport_checksum, addr, moved);
                    end
                    else if (c.protocol_number == PROTO_UDP && c.transport_checksum != 16'h0)
                    begin
                        r.out_transport_checksum = ones_patch(c.transport_checksum, addr, moved);
                        if (r.out_transport_checksum == 16'h0)
                            r.out_transport_checksum = CK_ONES;
                    end
                    if (c.direction == DIR_REV)
                        r.out_destination_address = moved;
                    else
                        r.out_source_address = moved;
                end
            end
        end
        return r;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.kind                = 1'($urandom);
        c.direction           = 1'($urandom);
        c.entry_index         = 4'($urandom);
        c.entry_inside_start  = $urandom;
        c.entry_outside_start = $urandom;
        c.entry_span          = $urandom;
        c.source_address      = $urandom;
        c.destination_address = $urandom;
        c.header_checksum     = 16'($urandom);
        c.protocol_number     = 8'($urandom);
        c.transport_checksum  = 16'($urandom);
        return c;
    endfunction

    // drive one beat; returns at the edge that takes it, start left high
    task automatic send_cmd(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (c.kind == KIND_ENTRY)
        begin
            nat_inside[c.entry_index]  = c.entry_inside_start;
            nat_outside[c.entry_index] = c.entry_outside_start;
            nat_span[c.entry_index]    = c.entry_span;
        end
        else
        begin
            pending_rewrites.insert(pending_rewrites.size(), rewrite_header(c));
        end
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_entry(input logic [3:0] idx, input logic [31:0] in_start,
                              input logic [31:0] out_start, input logic [31:0] span);
        cmd_t c;
        c = random_cmd();
        c.kind                = KIND_ENTRY;
        c.entry_index         = idx;
        c.entry_inside_start  = in_start;
        c.entry_outside_start = out_start;
        c.entry_span          = span;
        maybe_idle();
        send_cmd(c);
    endtask

    task automatic send_header(input logic dir, input logic [31:0] src, input logic [31:0] dst,
                               input logic [15:0] hck, input logic [7:0] proto,
                               input logic [15:0] tck);
        cmd_t c;
        c = random_cmd();
        c.kind                = KIND_HEADER;
        c.direction           = dir;
        c.source_address      = src;
        c.destination_address = dst;
        c.header_checksum     = hck;
        c.protocol_number     = proto;
        c.transport_checksum  = tck;
        maybe_idle();
        send_cmd(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rewrites.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_active_pairs(input logic [4:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        nat_active = value;
    endtask

    task automatic test_reset_passthrough();
        send_header(DIR_FWD, 32'h0, 32'h0, 16'h0, 8'h0, 16'h0);
        send_header(DIR_REV, '1, '1, '1, '1, '1);
        set_active_pairs(5'd0);
        send_header(DIR_FWD, 32'h0A00_0005, 32'h0, 16'h1234, PROTO_TCP, 16'h5678);
    endtask

    task automatic test_table_load();
        send_entry(4'd0, 32'h0A00_0000, 32'hC0A8_0000, 32'h0000_0100);
        send_entry(4'd1, 32'h0A00_0080, 32'h6400_0000, 32'h0000_0100);
        // inside range runs past the top of the address space
        send_entry(4'd2, 32'hFFFF_FF00, 32'h0100_0000, 32'h0000_0200);
        send_entry(4'd3, 32'h0B00_0000, 32'h0B00_0000, 32'h0000_0010);
        send_entry(4'd4, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        set_active_pairs(5'd5);
    endtask

    task automatic test_translate();
        send_header(DIR_FWD, 32'h0A00_0005, 32'h0808_0808, 16'hB1E6, PROTO_TCP, 16'h3C2D);
        send_header(DIR_REV, 32'h0808_0808, 32'hC0A8_0005, 16'h0000, PROTO_UDP, 16'h9A01);
        send_header(DIR_FWD, 32'h0A00_00FF, 32'h0101_0101, 16'hFFFF, PROTO_UDP, 16'h0000);
        send_header(DIR_FWD, 32'h0A00_0001, 32'h0202_0202, 16'h4321, 8'd1, 16'hDEAD);
        send_header(DIR_FWD, 32'h0A00_0090, 32'h0303_0303, 16'h1111, PROTO_TCP, 16'h2222);
        send_header(DIR_FWD, 32'h0A00_0150, 32'h0404_0404, 16'h7FFF, PROTO_TCP, 16'h8000);
        send_header(DIR_FWD, 32'hFFFF_FFFF, 32'h0505_0505, 16'h0001, PROTO_UDP, 16'hFFFE);
        send_header(DIR_FWD, 32'h0000_0000, 32'h0606_0606, 16'hFFFF, PROTO_TCP, 16'hFFFF);
        send_header(DIR_REV, 32'h0707_0707, 32'hFFFF_FFFF, 16'h0000, PROTO_TCP, 16'h0000);
    endtask

    task automatic test_udp_zero_result();
        // identity pair with all-ones checksum patches to zero
        send_header(DIR_FWD, 32'h0B00_0003, 32'h0909_0909, 16'hFFFF, PROTO_UDP, 16'hFFFF);
    endtask

    task automatic test_no_match();
        send_header(DIR_FWD, 32'h0C00_0000, 32'h0A00_0005, 16'hABCD, PROTO_TCP, 16'hEF01);
        send_header(DIR_REV, 32'hC0A8_0005, 32'h0A00_0005, 16'hABCD, PROTO_UDP, 16'hEF01);
    endtask

    task automatic test_active_limit();
        set_active_pairs(5'd1);
        send_header(DIR_FWD, 32'h0A00_0150, 32'h0, 16'h5555, PROTO_TCP, 16'hAAAA);
        send_header(DIR_FWD, 32'h0A00_0010, 32'h0, 16'h5555, PROTO_TCP, 16'hAAAA);
    endtask

    task automatic send_random_entry();
        logic [31:0] base;
        logic [31:0] span;
        base = $urandom;
        case ($urandom_range(0, 9))
            0: base = 32'h0;
            1: base = '1;
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: span = 32'd1;
            1: span = $urandom_range(1, 255);
            2: span = $urandom_range(1, 65535);
            3: span = $urandom | 32'h1;
            4: span = '1;
            5: span = (base == 32'h0) ? 32'h1 : ~base + 32'h1;
            default: span = $urandom_range(1, 4096);
        endcase
        send_entry(4'($urandom), base,
                   ($urandom_range(0, 7) == 0) ? base : $urandom, span);
    endtask

    task automatic send_random_header(input bit aimed);
        cmd_t        c;
        int unsigned lim;
        int unsigned i;
        logic [31:0] addr;
        c = random_cmd();
        c.kind = KIND_HEADER;
        lim = (nat_active > TABLE_DEPTH) ? TABLE_DEPTH : nat_active;
        if (aimed)
        begin
            i = (lim == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, lim - 1);
            addr = ((c.direction == DIR_REV) ? nat_outside[i] : nat_inside[i])
                   + ($urandom % nat_span[i]);
            if (c.direction == DIR_REV)
                c.destination_address = addr;
            else
                c.source_address = addr;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.protocol_number = PROTO_TCP;
            4, 5, 6, 7: c.protocol_number = PROTO_UDP;
            default: ;
        endcase
        if (c.protocol_number == PROTO_UDP && $urandom_range(0, 4) == 0)
            c.transport_checksum = 16'h0;
        case ($urandom_range(0, 15))
            0: c.transport_checksum = CK_ONES;
            1: c.header_checksum = CK_ONES;
            2: c.header_checksum = 16'h0;
            default: ;
        endcase
        maybe_idle();
        send_cmd(c);
    endtask

    task automatic test_random_traffic();
        logic [4:0] settings [8] = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd9, 5'd24, 5'd16};
        // fill the rest of the table so every active slot holds a range
        for (int k = 5; k < TABLE_DEPTH; k++)
        begin
            send_entry(4'(k), $urandom, $urandom, $urandom_range(1, 1 << 20));
        end
        foreach (settings[s])
        begin
            set_active_pairs(settings[s]);
            if (s == 7)
                idling_on = 1'b0;
            repeat (ITEMS_PER_SET)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: send_random_entry();
                    3, 4, 5: send_random_header(1'b0);
                    default: send_random_header(1'b1);
                endcase
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (pending_rewrites.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none actual %h", $time, result);
            end
            else
            begin
                want = pending_rewrites.pop_front();
                check_field("translated", 32'(want.translated), 32'(result.translated));
                check_field("out_source_address", want.out_source_address,
                            result.out_source_address);
                check_field("out_destination_address", want.out_destination_address,
                            result.out_destination_address);
                check_field("out_header_checksum", 32'(want.out_header_checksum),
                            32'(result.out_header_checksum));
                check_field("out_transport_checksum", 32'(want.out_transport_checksum),
                            32'(result.out_transport_checksum));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout after %0d idle cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_passthrough();
        test_table_load();
        test_translate();
        test_udp_zero_result();
        test_no_match();
        test_active_limit();
        test_random_traffic();
        drain();
        if (pending_rewrites.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, pending_rewrites.size());
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
hdl/snhr_pkg.sv
hdl/snhr_cell.sv
hdl/snhr_csum.sv
hdl/static_nat_header_rewrite_top.sv
hdl/snhr_check.sv
sim/static_nat_header_rewrite_top_tb.sv
